FILE: rtl/kli_pkg.sv
// Shared types, widths and codes for the keyframe linear interpolator.
package kli_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned IDX_W  = 4;
	localparam int unsigned CNT_W  = 5;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	localparam logic [CNT_W-1:0] KEY_COUNT_RST = CNT_W'(2);

	typedef struct packed {
		logic                     operation;
		logic [IDX_W-1:0]         key_index;
		logic signed [WORD_W-1:0] key_time;
		logic signed [WORD_W-1:0] key_value;
		logic signed [WORD_W-1:0] query_time;
	} kli_cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] result_value;
		logic                     write_ignored;
	} kli_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_SCAN,
		ST_DIV,
		ST_MUL,
		ST_FIN
	} kli_state_t;

endpackage

FILE: rtl/keyframe_linear_interpolator.sv
// Keyframe table with piecewise linear evaluation; divide, multiply and final add share one adder.
//
// Command channel: a beat on cmd is taken at a clock edge with start high and busy low.
// A write beat stores one time/value key; its result comes in the next cycle, busy stays
// low, and write_ignored flags an index at or beyond the effective key count.
// An evaluate beat with two or more keys in use raises busy until its result is out;
// with fewer keys it returns zero in the next cycle. An evaluate returns the first key's
// value when the query is at or before it, else the last key's value when at or after it,
// else interpolates in the segment ending at key k; with no bracketing segment (unsorted
// keys) it ends the scan with the last key's value. The scan takes one table read per
// cycle, then FRAC_BITS+1 restoring divide steps and FRAC_BITS+1 shift-add multiply steps
// run on the same adder, then one add.
// Default 16 keys / Q16.16.
// Result channel: done is high for exactly one cycle with the beat on result; there is
// no back-pressure, the receiver must take it.
// cfg_write_en/cfg_write_data set key_count; write it only while idle.
// Reset: key_count returns to 2 and every key reads as zero (per-entry valid bits).
module keyframe_linear_interpolator #(
	parameter int unsigned MAX_KEYS  = 16,
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write_en,
	input  logic [kli_pkg::CNT_W-1:0]             cfg_write_data,
	input  logic                                  start,
	input  kli_pkg::kli_cmd_t                     cmd,
	output logic                                  busy,
	output logic                                  done,
	output kli_pkg::kli_result_t                  result
);
	import kli_pkg::*;

	localparam int unsigned AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int unsigned NW  = $clog2(MAX_KEYS + 1);
	localparam int unsigned EW  = (NW > CNT_W) ? NW : CNT_W;
	localparam int unsigned SW  = $clog2(FRAC_BITS + 1);
	localparam int unsigned QW  = FRAC_BITS + 1;
	localparam int unsigned DW  = WORD_W + 1;
	localparam int unsigned PW  = DW + QW + 1;
	localparam logic [EW-1:0] MAX_N = EW'(MAX_KEYS);

	// table storage
	logic [WORD_W-1:0] times_mem [MAX_KEYS];
	logic [WORD_W-1:0] values_mem [MAX_KEYS];
	logic [MAX_KEYS-1:0] valid_q;
	logic signed [WORD_W-1:0] rd_time_q, rd_value_q;

	logic [CNT_W-1:0] key_count_q;
	kli_state_t state_q, state_d;

	logic signed [WORD_W-1:0] query_q, prev_t_q, prev_v_q, last_v_q, v0_q;
	logic [AW-1:0] cnt_q;
	logic [SW-1:0] step_q;
	logic [DW-1:0] r_q;
	logic [WORD_W-1:0] span_q;
	logic span_nz_q;
	logic [QW-1:0] q_q;
	logic signed [PW-1:0] acc_q;
	logic signed [DW-1:0] delta_q;

	logic done_q;
	kli_result_t result_q;

	logic [EW-1:0] eff_n;
	logic [AW-1:0] last_idx, raddr;
	logic accept, eval_ok, in_range;
	logic t_le_rd, t_ge_rd, t_ge_prev, seg_hit, at_last;
	logic signed [DW-1:0] d_diff, span_diff, v_diff;
	logic [PW-1:0] op_a, op_b, sum;
	logic cin, ge;
	logic [DW-1:0] r_next;
	logic finish;
	logic signed [WORD_W-1:0] finish_value;
	logic finish_ignored;

	assign eff_n    = (EW'(key_count_q) > MAX_N) ? MAX_N : EW'(key_count_q);
	assign last_idx = AW'(eff_n - EW'(1));
	assign accept   = start && !busy;
	assign eval_ok  = eff_n >= EW'(2);
	assign in_range = EW'(cmd.key_index) < eff_n;

	assign t_le_rd   = query_q <= rd_time_q;
	assign t_ge_rd   = query_q >= rd_time_q;
	assign t_ge_prev = query_q >= prev_t_q;
	assign seg_hit   = t_ge_prev && t_le_rd;
	assign at_last   = cnt_q == last_idx;

	assign d_diff    = {query_q[WORD_W-1], query_q} - {prev_t_q[WORD_W-1], prev_t_q};
	assign span_diff = {rd_time_q[WORD_W-1], rd_time_q} - {prev_t_q[WORD_W-1], prev_t_q};
	assign v_diff    = {rd_value_q[WORD_W-1], rd_value_q} - {prev_v_q[WORD_W-1], prev_v_q};

	// shared adder
	assign sum    = op_a + op_b + PW'(cin);
	assign ge     = !sum[PW-1] && span_nz_q;
	assign r_next = ge ? sum[DW-1:0] : r_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd.operation == OP_EVAL && eval_ok) state_d = ST_FIRST;
			end
			ST_FIRST: state_d = t_le_rd ? ST_IDLE : ST_LAST;
			ST_LAST:  state_d = t_ge_rd ? ST_IDLE : ST_SCAN;
			ST_SCAN: begin
				if (seg_hit) state_d = ST_DIV;
				else if (at_last) state_d = ST_IDLE;
			end
			ST_DIV: begin
				if (step_q == '0) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (step_q == '0) state_d = ST_FIN;
			end
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: read address, adder operands, finished beat
	always_comb begin
		busy           = state_q != ST_IDLE;
		raddr          = '0;
		op_a           = '0;
		op_b           = '0;
		cin            = 1'b0;
		finish         = 1'b0;
		finish_value   = '0;
		finish_ignored = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd.operation == OP_WRITE) begin
						finish         = 1'b1;
						finish_ignored = !in_range;
					end else if (!eval_ok) begin
						finish = 1'b1;
					end
				end
			end
			ST_FIRST: begin
				raddr = last_idx;
				if (t_le_rd) begin
					finish       = 1'b1;
					finish_value = rd_value_q;
				end
			end
			ST_LAST: begin
				raddr = AW'(1);
				if (t_ge_rd) begin
					finish       = 1'b1;
					finish_value = rd_value_q;
				end
			end
			ST_SCAN: begin
				raddr = at_last ? cnt_q : cnt_q + AW'(1);
				if (!seg_hit && at_last) begin
					finish       = 1'b1;
					finish_value = last_v_q;
				end
			end
			ST_DIV: begin
				op_a = PW'(r_q);
				op_b = ~PW'(span_q);
				cin  = 1'b1;
			end
			ST_MUL: begin
				op_a = acc_q <<< 1;
				op_b = q_q[QW-1] ? {{(PW-DW){delta_q[DW-1]}}, delta_q} : '0;
			end
			ST_FIN: begin
				op_a         = {{(PW-WORD_W){v0_q[WORD_W-1]}}, v0_q};
				op_b         = acc_q >>> FRAC_BITS;
				finish       = 1'b1;
				finish_value = sum[WORD_W-1:0];
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			key_count_q <= KEY_COUNT_RST;
			valid_q     <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (cfg_write_en) key_count_q <= cfg_write_data;
			if (accept && cmd.operation == OP_WRITE && in_range)
				valid_q[AW'(cmd.key_index)] <= 1'b1;
		end
	end

	// key memory, registered read; unwritten entries read as zero
	always_ff @(posedge clk) begin
		if (accept && cmd.operation == OP_WRITE && in_range) begin
			times_mem[AW'(cmd.key_index)]  <= cmd.key_time;
			values_mem[AW'(cmd.key_index)] <= cmd.key_value;
		end
		rd_time_q  <= valid_q[raddr] ? times_mem[raddr] : '0;
		rd_value_q <= valid_q[raddr] ? values_mem[raddr] : '0;
	end

	// datapath
	always_ff @(posedge clk) begin
		if (finish) begin
			result_q.result_value  <= finish_value;
			result_q.write_ignored <= finish_ignored;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) query_q <= cmd.query_time;
			end
			ST_FIRST: begin
				prev_t_q <= rd_time_q;
				prev_v_q <= rd_value_q;
			end
			ST_LAST: begin
				last_v_q <= rd_value_q;
				cnt_q    <= AW'(1);
			end
			ST_SCAN: begin
				if (seg_hit) begin
					r_q       <= {1'b0, d_diff[WORD_W-1:0]};
					span_q    <= span_diff[WORD_W-1:0];
					span_nz_q <= span_diff != '0;
					v0_q      <= prev_v_q;
					delta_q   <= v_diff;
					step_q    <= SW'(FRAC_BITS);
					q_q       <= '0;
				end else begin
					prev_t_q <= rd_time_q;
					prev_v_q <= rd_value_q;
					cnt_q    <= cnt_q + AW'(1);
				end
			end
			ST_DIV: begin
				q_q <= {q_q[QW-2:0], ge};
				r_q <= {r_next[DW-2:0], 1'b0};
				if (step_q == '0) begin
					step_q <= SW'(FRAC_BITS);
					acc_q  <= '0;
				end else begin
					step_q <= step_q - SW'(1);
				end
			end
			ST_MUL: begin
				acc_q  <= sum;
				q_q    <= q_q << 1;
				step_q <= step_q - SW'(1);
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while an evaluate is still running");

	a_eval_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.operation == OP_EVAL) |=> (busy || done))
		else $error("evaluate beat accepted without work or result");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.operation == OP_WRITE) |=> (done && result.result_value == '0))
		else $error("write beat result missing or nonzero");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q != '0 && cnt_q <= last_idx))
		else $error("segment scan index out of range");

endmodule
